@@ rtl/prax_pkg.sv @@
// ----------------------------------------------------------------------------
// prax_pkg: shared types and constants of the axis rotation pipeline
// Widths, CORDIC tables, axis codes and the stage side-band struct.
// ----------------------------------------------------------------------------
package prax_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_BITS    = 8;

    localparam int STAGES_USED = (CORDIC_STAGES < 8) ? 8 :
                                 ((CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES);

    // turn fraction of the cordic angle accumulator
    localparam int Z_WIDTH     = 32;
    localparam int SHIFT_WIDTH = 5;

    // quarter-turned coordinate plus guard bits plus cordic growth headroom
    localparam int ACC_WIDTH = COORD_WIDTH + GUARD_BITS + 4;
    // magnitude word, split at bit 32 for the gain multiply
    localparam int MAG_WIDTH = (ACC_WIDTH > 32) ? ACC_WIDTH : 33;
    localparam int GAIN_WIDTH = 31;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;
    localparam logic [1:0] AXIS_RESET = AXIS_Z;

    localparam logic [Z_WIDTH-1:0] ATAN_TURN [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // q31 inverse cordic gain, indexed by stage count minus 8
    localparam logic [GAIN_WIDTH-1:0] INV_GAIN [0:24] = '{
        31'd1304079014, 31'd1304069065, 31'd1304066577, 31'd1304065955,
        31'd1304065800, 31'd1304065761, 31'd1304065751, 31'd1304065749,
        31'd1304065748, 31'd1304065748, 31'd1304065748, 31'd1304065748,
        31'd1304065748, 31'd1304065748, 31'd1304065748, 31'd1304065748,
        31'd1304065748, 31'd1304065748, 31'd1304065748, 31'd1304065748,
        31'd1304065748, 31'd1304065748, 31'd1304065748, 31'd1304065748,
        31'd1304065748
    };

    localparam logic [GAIN_WIDTH-1:0] GAIN = INV_GAIN[STAGES_USED - 8];

    // travels beside the rotating pair through every stage
    typedef struct packed {
        logic                          valid;
        logic [1:0]                    axis;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } t_side;

endpackage

@@ rtl/point_rotate_about_axis.sv @@
// ----------------------------------------------------------------------------
// point_rotate_about_axis: rotate a 3d point about a principal axis
// Quarter-turn prerotation, a chain of cordic cells, gain and saturation.
// ----------------------------------------------------------------------------
// A point (signed Q16.16 x, y, z) and a binary angle are taken on every clock
// in which start is high; busy never rises, so one point per cycle streams in.
// The rotated point appears on the o_rot_* ports with o_done high for a single
// cycle, after passing through one entry register, one register per cordic
// cell, four gain/rounding stages and the output register. Results cannot be
// held off and must be taken when o_done shows them. o_clipped flags a
// component that was clamped to the signed range. The axis register (0 x,
// 1 y, 2 z, 3 no rotation; reset z) should be written only while no point is
// in flight.
module point_rotate_about_axis
    import prax_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic [ANGLE_WIDTH-1:0]        i_turn_angle,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_data,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_rot_x,
    output logic signed [COORD_WIDTH-1:0] o_rot_y,
    output logic signed [COORD_WIDTH-1:0] o_rot_z,
    output logic                          o_clipped
);

    localparam int LATENCY    = STAGES_USED + 6;
    localparam int GAIN_DEPTH = 4;

    logic [1:0]                    r_axis;
    logic [Z_WIDTH-1:0]            a32;
    logic [Z_WIDTH-1:0]            a_sum;
    logic [1:0]                    quad;
    logic signed [COORD_WIDTH-1:0] u_sel;
    logic signed [COORD_WIDTH-1:0] w_sel;
    logic signed [COORD_WIDTH:0]   u_ext;
    logic signed [COORD_WIDTH:0]   w_ext;
    logic signed [COORD_WIDTH:0]   u_q;
    logic signed [COORD_WIDTH:0]   w_q;
    t_side                         n_side0;
    t_side                         r_side0;
    logic signed [ACC_WIDTH-1:0]   r_u0;
    logic signed [ACC_WIDTH-1:0]   r_w0;
    logic signed [Z_WIDTH-1:0]     r_z0;

    logic signed [ACC_WIDTH-1:0]   u_chain [0:STAGES_USED];
    logic signed [ACC_WIDTH-1:0]   w_chain [0:STAGES_USED];
    logic signed [Z_WIDTH-1:0]     z_chain [0:STAGES_USED];
    t_side                         s_chain [0:STAGES_USED];

    t_side                         r_gside [0:GAIN_DEPTH-1];
    logic signed [COORD_WIDTH-1:0] g_u;
    logic signed [COORD_WIDTH-1:0] g_w;
    logic                          g_u_clip;
    logic                          g_w_clip;
    t_side                         fin;

    logic                          n_done;
    logic signed [COORD_WIDTH-1:0] n_rot_x;
    logic signed [COORD_WIDTH-1:0] n_rot_y;
    logic signed [COORD_WIDTH-1:0] n_rot_z;
    logic                          n_clipped;
    logic                          r_done;
    logic signed [COORD_WIDTH-1:0] r_rot_x;
    logic signed [COORD_WIDTH-1:0] r_rot_y;
    logic signed [COORD_WIDTH-1:0] r_rot_z;
    logic                          r_clipped;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_axis <= i_cfg_data;
        end
    end

    // quadrant split: residual angle lands in [-1/8, 1/8) turn
    always_comb begin
        a32   = {i_turn_angle, {(Z_WIDTH - ANGLE_WIDTH){1'b0}}};
        a_sum = a32 + (Z_WIDTH'(1) << (Z_WIDTH - 3));
        quad  = a_sum[Z_WIDTH-1:Z_WIDTH-2];
    end

    always_comb begin
        unique case (r_axis)
            AXIS_X: begin
                u_sel = i_coord_y;
                w_sel = i_coord_z;
            end
            AXIS_Y: begin
                u_sel = i_coord_z;
                w_sel = i_coord_x;
            end
            AXIS_Z: begin
                u_sel = i_coord_x;
                w_sel = i_coord_y;
            end
            AXIS_NONE: begin
                u_sel = i_coord_x;
                w_sel = i_coord_y;
            end
        endcase
        u_ext = (COORD_WIDTH + 1)'(u_sel);
        w_ext = (COORD_WIDTH + 1)'(w_sel);
        unique case (quad)
            2'd0: begin
                u_q = u_ext;
                w_q = w_ext;
            end
            2'd1: begin
                u_q = -w_ext;
                w_q = u_ext;
            end
            2'd2: begin
                u_q = -u_ext;
                w_q = -w_ext;
            end
            2'd3: begin
                u_q = w_ext;
                w_q = -u_ext;
            end
        endcase
        n_side0.valid = start && !busy;
        n_side0.axis  = r_axis;
        n_side0.x     = i_coord_x;
        n_side0.y     = i_coord_y;
        n_side0.z     = i_coord_z;
    end

    always_ff @(posedge i_clk) begin
        r_u0 <= {{(ACC_WIDTH - COORD_WIDTH - 1 - GUARD_BITS){u_q[COORD_WIDTH]}},
                 u_q, {GUARD_BITS{1'b0}}};
        r_w0 <= {{(ACC_WIDTH - COORD_WIDTH - 1 - GUARD_BITS){w_q[COORD_WIDTH]}},
                 w_q, {GUARD_BITS{1'b0}}};
        r_z0 <= $signed(a32 - {quad, {(Z_WIDTH - 2){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side0 <= '0;
        end else begin
            r_side0 <= n_side0;
        end
    end

    assign u_chain[0] = r_u0;
    assign w_chain[0] = r_w0;
    assign z_chain[0] = r_z0;
    assign s_chain[0] = r_side0;

    for (genvar k = 0; k < STAGES_USED; k++) begin : g_cell
        prax_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SHIFT_WIDTH'(k)),
            .i_atan  (ATAN_TURN[k]),
            .i_u     (u_chain[k]),
            .i_w     (w_chain[k]),
            .i_z     (z_chain[k]),
            .i_side  (s_chain[k]),
            .o_u     (u_chain[k+1]),
            .o_w     (w_chain[k+1]),
            .o_z     (z_chain[k+1]),
            .o_side  (s_chain[k+1])
        );
    end

    prax_gain u_gain_u (
        .i_clk   (i_clk),
        .i_acc   (u_chain[STAGES_USED]),
        .o_coord (g_u),
        .o_clip  (g_u_clip)
    );

    prax_gain u_gain_w (
        .i_clk   (i_clk),
        .i_acc   (w_chain[STAGES_USED]),
        .o_coord (g_w),
        .o_clip  (g_w_clip)
    );

    // side band keeps step with the gain stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < GAIN_DEPTH; j++) begin
                r_gside[j] <= '0;
            end
        end else begin
            r_gside[0] <= s_chain[STAGES_USED];
            for (int j = 1; j < GAIN_DEPTH; j++) begin
                r_gside[j] <= r_gside[j-1];
            end
        end
    end

    assign fin = r_gside[GAIN_DEPTH-1];

    always_comb begin
        n_done    = fin.valid;
        n_rot_x   = fin.x;
        n_rot_y   = fin.y;
        n_rot_z   = fin.z;
        n_clipped = fin.valid && (g_u_clip || g_w_clip);
        unique case (fin.axis)
            AXIS_X: begin
                n_rot_y = g_u;
                n_rot_z = g_w;
            end
            AXIS_Y: begin
                n_rot_z = g_u;
                n_rot_x = g_w;
            end
            AXIS_Z: begin
                n_rot_x = g_u;
                n_rot_y = g_w;
            end
            AXIS_NONE: begin
                n_clipped = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rot_x <= n_rot_x;
        r_rot_y <= n_rot_y;
        r_rot_z <= n_rot_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= 1'b0;
            r_clipped <= 1'b0;
        end else begin
            r_done    <= n_done;
            r_clipped <= n_clipped;
        end
    end

    assign o_done    = r_done;
    assign o_rot_x   = r_rot_x;
    assign o_rot_y   = r_rot_y;
    assign o_rot_z   = r_rot_z;
    assign o_clipped = r_clipped;

`ifndef SYNTH
    // every result strobe goes back to a transfer a fixed latency earlier
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LATENCY))
        else $error("result strobe without a matching start");

    // clip flag only rides on a result
    a_clip_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clipped |-> o_done)
        else $error("clipped raised outside a result");

    // quadrant split leaves the residual within an eighth turn
    a_residual_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side0.valid |-> (r_z0[Z_WIDTH-1:Z_WIDTH-3] == 3'b000 ||
                           r_z0[Z_WIDTH-1:Z_WIDTH-3] == 3'b111))
        else $error("cordic residual angle out of range");

    // the coordinate along the axis passes through untouched
    a_axis_x_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin.valid && fin.axis == AXIS_X) |=> (o_rot_x == $past(fin.x)))
        else $error("x changed on a rotation about x");

    a_axis_none_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin.valid && fin.axis == AXIS_NONE) |=>
            (o_rot_y == $past(fin.y) && o_rot_z == $past(fin.z) && !o_clipped))
        else $error("point changed with rotation off");
`endif

endmodule

@@ rtl/prax_cell.sv @@
// ----------------------------------------------------------------------------
// prax_cell: one cordic micro-rotation
// Turns the pair by +/- atan(2^-i) and registers it with its side band.
// ----------------------------------------------------------------------------
module prax_cell
    import prax_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [SHIFT_WIDTH-1:0]      i_shift,
    input  logic [Z_WIDTH-1:0]          i_atan,
    input  logic signed [ACC_WIDTH-1:0] i_u,
    input  logic signed [ACC_WIDTH-1:0] i_w,
    input  logic signed [Z_WIDTH-1:0]   i_z,
    input  t_side                       i_side,
    output logic signed [ACC_WIDTH-1:0] o_u,
    output logic signed [ACC_WIDTH-1:0] o_w,
    output logic signed [Z_WIDTH-1:0]   o_z,
    output t_side                       o_side
);

    logic signed [ACC_WIDTH-1:0] du;
    logic signed [ACC_WIDTH-1:0] dw;
    logic signed [ACC_WIDTH-1:0] n_u;
    logic signed [ACC_WIDTH-1:0] n_w;
    logic signed [Z_WIDTH-1:0]   n_z;
    logic signed [ACC_WIDTH-1:0] r_u;
    logic signed [ACC_WIDTH-1:0] r_w;
    logic signed [Z_WIDTH-1:0]   r_z;
    t_side                       r_side;

    always_comb begin
        du = i_w >>> i_shift;
        dw = i_u >>> i_shift;
        if (!i_z[Z_WIDTH-1]) begin
            n_u = i_u - du;
            n_w = i_w + dw;
            n_z = i_z - $signed(i_atan);
        end else begin
            n_u = i_u + du;
            n_w = i_w - dw;
            n_z = i_z + $signed(i_atan);
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;
        r_w <= n_w;
        r_z <= n_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    assign o_u    = r_u;
    assign o_w    = r_w;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

@@ rtl/prax_gain.sv @@
// ----------------------------------------------------------------------------
// prax_gain: cordic gain correction and saturation for one component
// Four stages: magnitude, split multiply, round, sign and clamp.
// ----------------------------------------------------------------------------
module prax_gain
    import prax_pkg::*;
(
    input  logic                          i_clk,
    input  logic signed [ACC_WIDTH-1:0]   i_acc,
    output logic signed [COORD_WIDTH-1:0] o_coord,
    output logic                          o_clip
);

    localparam int LO_PW = 32 + GAIN_WIDTH;
    localparam int HI_W  = MAG_WIDTH - 32;
    localparam int HI_PW = HI_W + GAIN_WIDTH;

    localparam logic signed [MAG_WIDTH:0] SAT_MAX =
        (MAG_WIDTH + 1)'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [MAG_WIDTH:0] SAT_MIN =
        (MAG_WIDTH + 1)'(-(64'sd1 <<< (COORD_WIDTH - 1)));
    localparam logic [MAG_WIDTH-1:0] RND_HALF =
        MAG_WIDTH'(64'd1 << (GUARD_BITS - 2));

    logic signed [MAG_WIDTH:0] acc_ext;
    logic signed [MAG_WIDTH:0] mag_ext;
    logic [MAG_WIDTH-1:0]      r_mag;
    logic                      r_neg1;
    logic [LO_PW-1:0]          r_lo;
    logic [HI_PW-1:0]          r_hi;
    logic                      r_neg2;
    logic [MAG_WIDTH-1:0]      h_sum;
    logic [MAG_WIDTH-1:0]      r_rnd;
    logic                      r_neg3;
    logic signed [MAG_WIDTH:0] val;
    logic signed [COORD_WIDTH-1:0] n_coord;
    logic                      n_clip;
    logic signed [COORD_WIDTH-1:0] r_coord;
    logic                      r_clip;

    always_comb begin
        acc_ext = (MAG_WIDTH + 1)'(i_acc);
        mag_ext = i_acc[ACC_WIDTH-1] ? -acc_ext : acc_ext;
    end

    // floor of m*g / 2^32, then round at the guard position
    always_comb begin
        h_sum = MAG_WIDTH'(r_hi) + MAG_WIDTH'(r_lo >> 32);
    end

    always_comb begin
        val = r_neg3 ? -$signed({1'b0, r_rnd}) : $signed({1'b0, r_rnd});
        if (val > SAT_MAX) begin
            n_coord = SAT_MAX[COORD_WIDTH-1:0];
            n_clip  = 1'b1;
        end else if (val < SAT_MIN) begin
            n_coord = SAT_MIN[COORD_WIDTH-1:0];
            n_clip  = 1'b1;
        end else begin
            n_coord = val[COORD_WIDTH-1:0];
            n_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= mag_ext[MAG_WIDTH-1:0];
        r_neg1  <= i_acc[ACC_WIDTH-1];
        r_lo    <= LO_PW'(r_mag[31:0]) * LO_PW'(GAIN);
        r_hi    <= HI_PW'(r_mag[MAG_WIDTH-1:32]) * HI_PW'(GAIN);
        r_neg2  <= r_neg1;
        r_rnd   <= (h_sum + RND_HALF) >> (GUARD_BITS - 1);
        r_neg3  <= r_neg2;
        r_coord <= n_coord;
        r_clip  <= n_clip;
    end

    assign o_coord = r_coord;
    assign o_clip  = r_clip;

endmodule

@@ tb/sv/rotation_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_checker: result checker of the axis rotation pipeline
// Tracks the axis register, predicts every accepted point bit for bit with
// its own cordic model and compares each result against the oldest one.
// ----------------------------------------------------------------------------
module rotation_checker
    import prax_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic [ANGLE_WIDTH-1:0]        i_turn_angle,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [1:0]                    i_cfg_data,
    input  logic                          i_done,
    input  logic signed [COORD_WIDTH-1:0] i_rot_x,
    input  logic signed [COORD_WIDTH-1:0] i_rot_y,
    input  logic signed [COORD_WIDTH-1:0] i_rot_z,
    input  logic                          i_clipped,
    output int                            o_mismatches,
    output int                            o_in_flight
);

    localparam int GAIN_SHIFT = 31 + GUARD_BITS;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic                          clipped;
    } t_rot_point;

    t_rot_point  expected_points [$];
    t_rot_point  oldest;
    logic [1:0]  axis_sel;
    int          mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // q31 gain multiply split at bit 32, low partial product truncated
    function automatic longint scale_gain(input longint v);
        bit [63:0] m;
        bit [63:0] hi;
        bit [63:0] lo;
        bit [63:0] h;
        bit [63:0] rv;
        m  = (v < 0) ? 64'(-v) : 64'(v);
        hi = (m >> 32) * 64'(GAIN);
        lo = (m & 64'hFFFF_FFFF) * 64'(GAIN);
        h  = hi + (lo >> 32);
        rv = (h + (64'd1 << (GAIN_SHIFT - 33))) >> (GAIN_SHIFT - 32);
        return (v < 0) ? -longint'(rv) : longint'(rv);
    endfunction

    function automatic longint clamp_coord(input longint v, inout bit clip);
        longint lim;
        lim = (longint'(1) << (COORD_WIDTH - 1)) - 1;
        if (v > lim) begin
            clip = 1'b1;
            return lim;
        end
        if (v < -lim - 1) begin
            clip = 1'b1;
            return -lim - 1;
        end
        return v;
    endfunction

    function automatic t_rot_point rotate_point(
        input logic [1:0]                    axis,
        input logic signed [COORD_WIDTH-1:0] px,
        input logic signed [COORD_WIDTH-1:0] py,
        input logic signed [COORD_WIDTH-1:0] pz,
        input logic [ANGLE_WIDTH-1:0]        ang
    );
        longint     p [3];
        longint     u;
        longint     w;
        longint     t;
        longint     du;
        longint     dw;
        longint     zacc;
        logic [31:0] a32;
        logic [31:0] sum;
        logic [31:0] rr;
        logic [1:0]  q;
        int          iu;
        int          iw;
        bit          clip;
        t_rot_point  res;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        clip = 1'b0;
        if (axis != AXIS_NONE) begin
            // (u, w) plane: (y, z) about x, (z, x) about y, (x, y) about z
            iu   = (axis == AXIS_X) ? 1 : ((axis == AXIS_Y) ? 2 : 0);
            iw   = (axis == AXIS_X) ? 2 : ((axis == AXIS_Y) ? 0 : 1);
            a32  = 32'(ang) << (32 - ANGLE_WIDTH);
            sum  = a32 + 32'h2000_0000;
            q    = sum[31:30];
            rr   = a32 - {q, 30'd0};
            zacc = longint'(signed'(rr));
            u    = p[iu];
            w    = p[iw];
            case (q)
                2'd1: begin
                    t = u; u = -w; w = t;
                end
                2'd2: begin
                    u = -u; w = -w;
                end
                2'd3: begin
                    t = u; u = w; w = -t;
                end
                default: ;
            endcase
            u = u * (longint'(1) << GUARD_BITS);
            w = w * (longint'(1) << GUARD_BITS);
            for (int i = 0; i < STAGES_USED; i++) begin
                du = w >>> i;
                dw = u >>> i;
                if (zacc >= 0) begin
                    u    = u - du;
                    w    = w + dw;
                    zacc = zacc - longint'(ATAN_TURN[i]);
                end else begin
                    u    = u + du;
                    w    = w - dw;
                    zacc = zacc + longint'(ATAN_TURN[i]);
                end
            end
            p[iu] = clamp_coord(scale_gain(u), clip);
            p[iw] = clamp_coord(scale_gain(w), clip);
        end
        res.x       = COORD_WIDTH'(p[0]);
        res.y       = COORD_WIDTH'(p[1]);
        res.z       = COORD_WIDTH'(p[2]);
        res.clipped = clip;
        return res;
    endfunction

    task automatic compare_field(
        input string                         name,
        input logic signed [COORD_WIDTH-1:0] want,
        input logic signed [COORD_WIDTH-1:0] got
    );
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // results leave before new points enter: latency is never zero
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            axis_sel = AXIS_RESET;
            expected_points.delete();
            o_in_flight <= 0;
        end else begin
            if (i_done) begin
                if (expected_points.size() == 0) begin
                    $error("result with no point in flight: x %0d y %0d z %0d clipped %0d",
                           i_rot_x, i_rot_y, i_rot_z, i_clipped);
                    mismatch_count++;
                end else begin
                    oldest = expected_points.pop_front();
                    compare_field("rot_x", oldest.x, i_rot_x);
                    compare_field("rot_y", oldest.y, i_rot_y);
                    compare_field("rot_z", oldest.z, i_rot_z);
                    compare_field("clipped", COORD_WIDTH'(oldest.clipped),
                                  COORD_WIDTH'(i_clipped));
                end
            end
            if (i_start && !i_busy) begin
                expected_points.push_back(rotate_point(axis_sel, i_coord_x, i_coord_y,
                                                       i_coord_z, i_turn_angle));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                axis_sel = i_cfg_data;
            end
            o_in_flight <= expected_points.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the axis rotation pipeline
// Directed corner points under every axis code, then random points with
// bursts of idle cycles; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb;
    import prax_pkg::*;

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam int PHASE_POINTS = 165;
    localparam int TAIL_CYCLES  = STAGES_USED + 16;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic [ANGLE_WIDTH-1:0]        turn_angle;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [1:0]                    cfg_data;
    logic                          done;
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;
    logic                          clipped;
    int                            mismatch_count;
    int                            in_flight;
    int                            gap_pct;

    point_rotate_about_axis dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_coord_x    (coord_x),
        .i_coord_y    (coord_y),
        .i_coord_z    (coord_z),
        .i_turn_angle (turn_angle),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_done       (done),
        .o_rot_x      (rot_x),
        .o_rot_y      (rot_y),
        .o_rot_z      (rot_z),
        .o_clipped    (clipped)
    );

    rotation_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_coord_x    (coord_x),
        .i_coord_y    (coord_y),
        .i_coord_z    (coord_z),
        .i_turn_angle (turn_angle),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_done       (done),
        .i_rot_x      (rot_x),
        .i_rot_y      (rot_y),
        .i_rot_z      (rot_z),
        .i_clipped    (clipped),
        .o_mismatches (mismatch_count),
        .o_in_flight  (in_flight)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            6: begin
                case ($urandom_range(0, 5))
                    0:       return C_MAX;
                    1:       return C_MIN;
                    2:       return '0;
                    3:       return '1;
                    4:       return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
            7: begin
                if ($urandom_range(0, 1) == 1) return C_MAX - $urandom_range(0, 255);
                return C_MIN + $urandom_range(0, 255);
            end
            default: return $signed($urandom) >>> $urandom_range(1, 24);
        endcase
    endfunction

    // quadrant borders sit at odd eighths of a turn
    function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
        if ($urandom_range(0, 9) < 7) return ANGLE_WIDTH'($urandom_range(0, 65535));
        case ($urandom_range(0, 10))
            0:       return 16'h0000;
            1:       return 16'h1FFF;
            2:       return 16'h2000;
            3:       return 16'h2001;
            4:       return 16'h4000;
            5:       return 16'h6000;
            6:       return 16'h8000;
            7:       return 16'hA000;
            8:       return 16'hC000;
            9:       return 16'hE000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic put_point(
        input logic signed [COORD_WIDTH-1:0] x,
        input logic signed [COORD_WIDTH-1:0] y,
        input logic signed [COORD_WIDTH-1:0] z,
        input logic [ANGLE_WIDTH-1:0]        a
    );
        start      <= 1'b1;
        coord_x    <= x;
        coord_y    <= y;
        coord_z    <= z;
        turn_angle <= a;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (in_flight != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_axis(input logic [1:0] axis);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= axis;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_corner_points();
        put_point('0, '0, '0, 16'h0000);
        put_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h4000);
        put_point(C_MAX, C_MAX, C_MAX, 16'h2000);
        put_point(C_MIN, C_MIN, C_MIN, 16'h8000);
        put_point(C_MIN, C_MAX, '1, 16'hFFFF);
        put_point(32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F, 16'h1FFF);
    endtask

    task automatic send_random_point();
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        put_point(pick_coord(), pick_coord(), pick_coord(), pick_angle());
    endtask

    initial begin
        logic [1:0] axis_plan [0:7];
        axis_plan = '{AXIS_Y, AXIS_Z, AXIS_X, AXIS_NONE, AXIS_X, AXIS_Z, AXIS_X, AXIS_Y};
        axis_plan[4] = 2'($urandom_range(0, 3));
        gap_pct    = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        coord_x    <= '0;
        coord_y    <= '0;
        coord_z    <= '0;
        turn_angle <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= AXIS_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners under the reset axis first, then every other code
        send_corner_points();
        set_axis(AXIS_X);
        send_corner_points();
        set_axis(AXIS_Y);
        send_corner_points();
        set_axis(AXIS_NONE);
        send_corner_points();

        for (int ph = 0; ph < 8; ph++) begin
            set_axis(axis_plan[ph]);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                if (n % 30 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       gap_pct = 0;
                        1:       gap_pct = 15;
                        default: gap_pct = 50;
                    endcase
                    if (ph == 7) gap_pct = 0;
                end
                // hold off once until the pipeline is empty
                if (ph == 1 && n == PHASE_POINTS / 2) drain();
                send_random_point();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
